FILE: design/ogms_pkg.sv
// ----------------------------------------------------------------------------
// Oriented grid max store package
// Sizes, codes, payload types and the command and status bundles that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
package ogms_pkg;

  localparam int MAX_CELLS_X     = 64;
  localparam int MAX_CELLS_Y     = 64;
  localparam int MAX_CELLS_ALPHA = 16;

  localparam int XW = (MAX_CELLS_X > 1) ? $clog2(MAX_CELLS_X) : 1;
  localparam int YW = (MAX_CELLS_Y > 1) ? $clog2(MAX_CELLS_Y) : 1;
  localparam int AW = (MAX_CELLS_ALPHA > 1) ? $clog2(MAX_CELLS_ALPHA) : 1;

  localparam int SXW = XW + 1;
  localparam int SYW = YW + 1;
  localparam int SAW = AW + 1;

  localparam int ADDR_W = XW + YW + AW;
  localparam int DEPTH  = 1 << ADDR_W;

  localparam int REG_W = 7;
  localparam int IDX_W = 2;

  localparam logic [IDX_W-1:0] REG_SIZE_X     = 2'd0;
  localparam logic [IDX_W-1:0] REG_SIZE_Y     = 2'd1;
  localparam logic [IDX_W-1:0] REG_SIZE_ALPHA = 2'd2;

  localparam logic [6:0] SIZE_X_RESET     = 7'd64;
  localparam logic [6:0] SIZE_Y_RESET     = 7'd64;
  localparam logic [4:0] SIZE_ALPHA_RESET = 5'd16;

  localparam logic [2:0] KIND_WRITE    = 3'd0;
  localparam logic [2:0] KIND_WRITE_NB = 3'd1;
  localparam logic [2:0] KIND_READ     = 3'd2;
  localparam logic [2:0] KIND_BEST     = 3'd3;
  localparam logic [2:0] KIND_CLEAR    = 3'd4;

  typedef struct packed {
    logic [2:0]        kind;
    logic signed [7:0] cell_x;
    logic signed [7:0] cell_y;
    logic signed [7:0] cell_alpha;
    logic [7:0]        new_value;
  } item_t;

  typedef struct packed {
    logic        hit;
    logic [7:0]  entry;
    logic [3:0]  best_alpha;
    logic [7:0]  max_entry;
    logic [31:0] cells_filled;
  } result_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] index;
    logic [REG_W-1:0] data;
  } cfg_wr_t;

  typedef enum logic [2:0] {
    MODE_NONE,
    MODE_WRITE,
    MODE_WRITE_NB,
    MODE_READ,
    MODE_BEST,
    MODE_CLEAR
  } mode_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic sweep;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    mode_t in_mode;
    logic  last;
    logic  sweep_last;
  } dp_status_t;

endpackage

FILE: design/ogms_item_if.sv
// ----------------------------------------------------------------------------
// Oriented grid max store item channel
// Valid and ready handshake carrying one request item.
// ----------------------------------------------------------------------------
interface ogms_item_if;
  logic           valid;
  logic           ready;
  ogms_pkg::item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/ogms_result_if.sv
// ----------------------------------------------------------------------------
// Oriented grid max store result channel
// Valid and ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface ogms_result_if;
  logic             valid;
  logic             ready;
  ogms_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/ogms_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual port RAM
// One write port and one read port with registered read data. A read at the
// address being written returns the old contents.
// ----------------------------------------------------------------------------
module ogms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/ogms_datapath.sv
// ----------------------------------------------------------------------------
// Oriented grid max store datapath
// Size registers, cell address sequencer, grid memory with a pipelined
// read-modify-write stage, statistics and the result register.
// ----------------------------------------------------------------------------
module ogms_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  ogms_pkg::cfg_wr_t    cfg,
  input  ogms_pkg::item_t      item,
  input  ogms_pkg::dp_cmd_t    cmd,
  output ogms_pkg::dp_status_t status,
  output ogms_pkg::result_t    result
);

  localparam int XW     = ogms_pkg::XW;
  localparam int YW     = ogms_pkg::YW;
  localparam int AW     = ogms_pkg::AW;
  localparam int SXW    = ogms_pkg::SXW;
  localparam int SYW    = ogms_pkg::SYW;
  localparam int SAW    = ogms_pkg::SAW;
  localparam int ADDR_W = ogms_pkg::ADDR_W;

  logic [6:0] size_x;
  logic [6:0] size_y;
  logic [4:0] size_alpha;

  logic [SXW-1:0] sx;
  logic [SYW-1:0] sy;
  logic [SAW-1:0] sa;
  logic [SXW-1:0] sxm1;
  logic [SYW-1:0] sym1;
  logic [SAW-1:0] sam1;

  logic [31:0]   ux;
  logic [31:0]   uy;
  logic [31:0]   ua;
  logic          xy_ok;
  logic          all_ok;
  logic [XW-1:0] xi;
  logic [YW-1:0] yi;
  logic [AW-1:0] ai;
  ogms_pkg::mode_t in_mode;

  ogms_pkg::mode_t mode_r;
  logic [7:0]    v_r;
  logic [XW-1:0] gi;
  logic [YW-1:0] gj;
  logic [AW-1:0] gk;
  logic [XW-1:0] x0;
  logic [XW-1:0] x1;
  logic [YW-1:0] y0;
  logic [YW-1:0] y1;
  logic [AW-1:0] a0;
  logic [AW-1:0] a1;
  logic          ctr_ph;
  logic          first_issue;
  logic          last;

  logic [ADDR_W-1:0] rd_addr;
  logic              p_valid;
  logic              p_first;
  logic              p_fwd;
  logic [ADDR_W-1:0] p_addr;
  logic [AW-1:0]     p_k;
  logic [7:0]        rdata;
  logic [7:0]        old;
  logic              rmw;
  logic              acc;
  logic              rmw_we;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [ADDR_W-1:0] clr_cnt;

  logic [7:0]    rmax;
  logic [31:0]   cnt;
  logic [7:0]    entry_r;
  logic [AW-1:0] best_r;
  logic          stats_clr;
  ogms_pkg::result_t res_r;

  // Effective sizes are the register values clamped to one and the maximum.
  always_comb begin
    if (size_x == 7'd0) begin
      sx = SXW'(1);
    end else if (32'(size_x) > ogms_pkg::MAX_CELLS_X) begin
      sx = SXW'(ogms_pkg::MAX_CELLS_X);
    end else begin
      sx = SXW'(size_x);
    end
    if (size_y == 7'd0) begin
      sy = SYW'(1);
    end else if (32'(size_y) > ogms_pkg::MAX_CELLS_Y) begin
      sy = SYW'(ogms_pkg::MAX_CELLS_Y);
    end else begin
      sy = SYW'(size_y);
    end
    if (size_alpha == 5'd0) begin
      sa = SAW'(1);
    end else if (32'(size_alpha) > ogms_pkg::MAX_CELLS_ALPHA) begin
      sa = SAW'(ogms_pkg::MAX_CELLS_ALPHA);
    end else begin
      sa = SAW'(size_alpha);
    end
  end

  assign sxm1 = sx - SXW'(1);
  assign sym1 = sy - SYW'(1);
  assign sam1 = sa - SAW'(1);

  assign ux = {24'd0, item.cell_x};
  assign uy = {24'd0, item.cell_y};
  assign ua = {24'd0, item.cell_alpha};

  assign xy_ok  = !item.cell_x[7] && !item.cell_y[7] && (ux < 32'(sx)) && (uy < 32'(sy));
  assign all_ok = xy_ok && !item.cell_alpha[7] && (ua < 32'(sa));

  assign xi = ux[XW-1:0];
  assign yi = uy[YW-1:0];
  assign ai = ua[AW-1:0];

  always_comb begin
    unique case (item.kind)
      ogms_pkg::KIND_WRITE:    in_mode = all_ok ? ogms_pkg::MODE_WRITE : ogms_pkg::MODE_NONE;
      ogms_pkg::KIND_WRITE_NB: in_mode = all_ok ? ogms_pkg::MODE_WRITE_NB : ogms_pkg::MODE_NONE;
      ogms_pkg::KIND_READ:     in_mode = all_ok ? ogms_pkg::MODE_READ : ogms_pkg::MODE_NONE;
      ogms_pkg::KIND_BEST:     in_mode = xy_ok ? ogms_pkg::MODE_BEST : ogms_pkg::MODE_NONE;
      ogms_pkg::KIND_CLEAR:    in_mode = ogms_pkg::MODE_CLEAR;
      default:                 in_mode = ogms_pkg::MODE_NONE;
    endcase
  end

  assign stats_clr = cmd.load && (in_mode == ogms_pkg::MODE_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x     <= ogms_pkg::SIZE_X_RESET;
      size_y     <= ogms_pkg::SIZE_Y_RESET;
      size_alpha <= ogms_pkg::SIZE_ALPHA_RESET;
    end else if (cfg.we) begin
      unique case (cfg.index)
        ogms_pkg::REG_SIZE_X:     size_x     <= cfg.data;
        ogms_pkg::REG_SIZE_Y:     size_y     <= cfg.data;
        ogms_pkg::REG_SIZE_ALPHA: size_alpha <= cfg.data[4:0];
        default: ;
      endcase
    end
  end

  // The centre cell goes first; a neighbor write then walks the clamped
  // block with alpha innermost.
  always_comb begin
    case (mode_r)
      ogms_pkg::MODE_WRITE_NB: last = !ctr_ph && (gi == x1) && (gj == y1) && (gk == a1);
      ogms_pkg::MODE_BEST:     last = (gk == sam1[AW-1:0]);
      default:                 last = 1'b1;
    endcase
  end

  assign rd_addr = {gi, gj, gk};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r      <= in_mode;
      v_r         <= item.new_value;
      gi          <= xi;
      gj          <= yi;
      gk          <= (in_mode == ogms_pkg::MODE_BEST) ? AW'(0) : ai;
      ctr_ph      <= (in_mode != ogms_pkg::MODE_BEST);
      first_issue <= 1'b1;
      x0          <= (xi != XW'(0)) ? xi - XW'(1) : XW'(0);
      y0          <= (yi != YW'(0)) ? yi - YW'(1) : YW'(0);
      a0          <= (ai != AW'(0)) ? ai - AW'(1) : AW'(0);
      x1          <= (({1'b0, xi} + SXW'(1)) < sx) ? xi + XW'(1) : sxm1[XW-1:0];
      y1          <= (({1'b0, yi} + SYW'(1)) < sy) ? yi + YW'(1) : sym1[YW-1:0];
      a1          <= (({1'b0, ai} + SAW'(1)) < sa) ? ai + AW'(1) : sam1[AW-1:0];
    end else if (cmd.issue) begin
      first_issue <= 1'b0;
      if (mode_r == ogms_pkg::MODE_BEST) begin
        gk <= gk + AW'(1);
      end else if (ctr_ph) begin
        ctr_ph <= 1'b0;
        gi     <= x0;
        gj     <= y0;
        gk     <= a0;
      end else if (gk == a1) begin
        gk <= a0;
        if (gj == y1) begin
          gj <= y0;
          gi <= gi + XW'(1);
        end else begin
          gj <= gj + YW'(1);
        end
      end else begin
        gk <= gk + AW'(1);
      end
    end
  end

  // Second stage: data of the cell read in the cycle before. A cell written in
  // the cycle of its own read takes the written value, which is always v_r.
  assign old    = p_fwd ? v_r : rdata;
  assign rmw    = (mode_r == ogms_pkg::MODE_WRITE) || (mode_r == ogms_pkg::MODE_WRITE_NB);
  assign acc    = rmw && (old <= v_r);
  assign rmw_we = p_valid && acc;

  assign ram_we    = cmd.sweep || rmw_we;
  assign ram_waddr = cmd.sweep ? clr_cnt : p_addr;
  assign ram_wdata = cmd.sweep ? 8'd0 : v_r;

  ogms_ram #(
    .WIDTH(8),
    .DEPTH(ogms_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.issue),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      p_fwd   <= 1'b0;
      clr_cnt <= '0;
      rmax    <= 8'd0;
      cnt     <= 32'd0;
    end else begin
      p_valid <= cmd.issue;
      p_fwd   <= rmw_we && cmd.issue && (rd_addr == p_addr);
      if (cmd.sweep) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
      if (stats_clr) begin
        rmax <= 8'd0;
        cnt  <= 32'd0;
      end else if (rmw_we) begin
        if (old == 8'd0 && cnt != '1) begin
          cnt <= cnt + 32'd1;
        end
        if (v_r > rmax) begin
          rmax <= v_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      p_addr  <= rd_addr;
      p_first <= first_issue;
      p_k     <= gk;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      entry_r <= 8'd0;
      best_r  <= AW'(0);
    end else if (p_valid) begin
      case (mode_r)
        ogms_pkg::MODE_WRITE, ogms_pkg::MODE_WRITE_NB: begin
          if (p_first) begin
            entry_r <= acc ? v_r : old;
          end
        end
        ogms_pkg::MODE_READ: begin
          if (p_first) begin
            entry_r <= old;
          end
        end
        ogms_pkg::MODE_BEST: begin
          if (p_first || old > entry_r) begin
            entry_r <= old;
            best_r  <= p_k;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_r.hit          <= (mode_r != ogms_pkg::MODE_NONE) && (mode_r != ogms_pkg::MODE_CLEAR);
      res_r.entry        <= entry_r;
      res_r.best_alpha   <= 4'(best_r);
      res_r.max_entry    <= rmax;
      res_r.cells_filled <= cnt;
    end
  end

  assign result = res_r;

  assign status.in_mode    = in_mode;
  assign status.last       = last;
  assign status.sweep_last = &clr_cnt;

  a_sweep_quiet: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep |-> !p_valid && !cmd.issue)
    else $error("clearing sweep overlaps a cell access");

  a_best_no_write: assert property (@(posedge clk) disable iff (rst)
    p_valid && mode_r == ogms_pkg::MODE_BEST |-> !ram_we)
    else $error("orientation scan wrote the grid");

  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    !stats_clr |=> cnt >= $past(cnt))
    else $error("filled count went down without a clear");

endmodule

FILE: design/ogms_ctrl.sv
// ----------------------------------------------------------------------------
// Oriented grid max store controller
// State machine that sequences the clearing sweep, the cell accesses of one
// item and the hand-off to the result register.
// ----------------------------------------------------------------------------
module ogms_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  ogms_pkg::dp_status_t status,
  output ogms_pkg::dp_cmd_t    cmd
);

  typedef enum logic [5:0] {
    ST_INIT   = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_RUN    = 6'b000100,
    ST_DRAIN  = 6'b001000,
    ST_CLEAR  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      ST_INIT: begin
        cmd.sweep = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (status.in_mode)
            ogms_pkg::MODE_CLEAR: state_next = ST_CLEAR;
            ogms_pkg::MODE_NONE:  state_next = ST_FINISH;
            default:              state_next = ST_RUN;
          endcase
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (status.last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_CLEAR: begin
        cmd.sweep = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_finish_waits: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH && out_valid && !out_ready |=> state == ST_FINISH && out_valid)
    else $error("result overwritten before its transfer");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN && status.last |=> state == ST_DRAIN && !cmd.issue)
    else $error("cell sequence did not stop at its last cell");

endmodule

FILE: design/oriented_grid_max_store.sv
// ----------------------------------------------------------------------------
// Oriented grid max store
// Grid of 8-bit reachability values over x, y and orientation cells with
// keep-the-larger writes, neighbor writes, reads and best orientation scans.
// ----------------------------------------------------------------------------
// The grid lives in one memory with a read port and a write port; one cell is
// touched per cycle with the read-modify-write pipelined across consecutive
// cells. A write or read touches one cell, a write with neighbors the centre
// plus up to 27 block cells, a best orientation the effective size_alpha
// cells. An item with indices out of range or an unknown kind touches no cell.
// A result that waits for its transfer holds the next item in its last cycle.
// The next item is taken while a result still waits for its transfer. After
// reset, and for every clear item, a sweep zeroes all 65536 cells of the
// memory one cell per cycle; no item is taken during the sweep, configuration
// writes are. Size registers are to be written only while the block is idle;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module oriented_grid_max_store (
  input  logic                          clk,
  input  logic                          rst,
  ogms_item_if.sink                     item,
  ogms_result_if.source                 result,
  input  logic                          wr_en,
  input  logic [ogms_pkg::IDX_W-1:0]    wr_index,
  input  logic [ogms_pkg::REG_W-1:0]    wr_data
);

  ogms_pkg::cfg_wr_t    cfg;
  ogms_pkg::dp_cmd_t    cmd;
  ogms_pkg::dp_status_t status;

  assign cfg.we    = wr_en;
  assign cfg.index = wr_index;
  assign cfg.data  = wr_data;

  ogms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  ogms_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (item.data),
    .cmd    (cmd),
    .status (status),
    .result (result.data)
  );

endmodule

FILE: tb/tb_oriented_grid_max_store.sv
// ----------------------------------------------------------------------------
// Oriented grid max store testbench
// A driver sends request items from a queue over the item channel. At each
// transfer a local grid model predicts the result. A monitor compares every
// result transfer with the oldest prediction, field by field. The run starts
// with a directed sequence and then goes through random phases under several
// size settings, the extremes among them. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_oriented_grid_max_store;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 40;
  localparam int GRID_CELLS = ogms_pkg::MAX_CELLS_X * ogms_pkg::MAX_CELLS_Y *
                              ogms_pkg::MAX_CELLS_ALPHA;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [ogms_pkg::IDX_W-1:0] wr_index = '0;
  logic [ogms_pkg::REG_W-1:0] wr_data = '0;

  ogms_item_if item_ch ();
  ogms_result_if result_ch ();

  oriented_grid_max_store dut (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .result(result_ch),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  bit [7:0] grid_cells [GRID_CELLS];
  bit [7:0] peak_value;
  bit [31:0] filled_total;
  bit [6:0] size_x_reg = ogms_pkg::SIZE_X_RESET;
  bit [6:0] size_y_reg = ogms_pkg::SIZE_Y_RESET;
  bit [4:0] size_alpha_reg = ogms_pkg::SIZE_ALPHA_RESET;

  ogms_pkg::item_t queued_requests[$];
  ogms_pkg::result_t awaited_results[$];

  bit sender_idles;
  bit receiver_idles;
  int src_gap;
  int snk_gap;
  int cycle_count;
  int mismatches;
  int results_checked;
  int requests_sent;
  int settings_tried;
  int kind_seen [8];

  function automatic void queue_request(ogms_pkg::item_t r);
    queued_requests.insert(queued_requests.size(), r);
  endfunction

  function automatic void note_prediction(ogms_pkg::result_t r);
    awaited_results.insert(awaited_results.size(), r);
  endfunction

  function automatic int eff_size(int reg_value, int max_value);
    if (reg_value < 1) return 1;
    if (reg_value > max_value) return max_value;
    return reg_value;
  endfunction

  function automatic int grid_index(int x, int y, int a);
    return (x * ogms_pkg::MAX_CELLS_Y + y) * ogms_pkg::MAX_CELLS_ALPHA + a;
  endfunction

  function automatic void keep_larger(int x, int y, int a, bit [7:0] v);
    int idx;
    idx = grid_index(x, y, a);
    if (grid_cells[idx] <= v) begin
      if (grid_cells[idx] == 8'd0 && filled_total != 32'hFFFF_FFFF) filled_total++;
      if (v > peak_value) peak_value = v;
      grid_cells[idx] = v;
    end
  endfunction

  function automatic ogms_pkg::result_t grid_step(ogms_pkg::item_t req);
    int x, y, a, sx, sy, sa, i, j, k, top, e;
    bit xy_ok, all_ok;
    ogms_pkg::result_t r;
    x = int'(req.cell_x);
    y = int'(req.cell_y);
    a = int'(req.cell_alpha);
    sx = eff_size(int'(size_x_reg), ogms_pkg::MAX_CELLS_X);
    sy = eff_size(int'(size_y_reg), ogms_pkg::MAX_CELLS_Y);
    sa = eff_size(int'(size_alpha_reg), ogms_pkg::MAX_CELLS_ALPHA);
    xy_ok = x >= 0 && y >= 0 && x < sx && y < sy;
    all_ok = xy_ok && a >= 0 && a < sa;
    r = '0;
    case (req.kind)
      ogms_pkg::KIND_WRITE, ogms_pkg::KIND_WRITE_NB: begin
        if (all_ok) begin
          keep_larger(x, y, a, req.new_value);
          if (req.kind == ogms_pkg::KIND_WRITE_NB) begin
            for (i = (x > 0 ? x - 1 : 0); i <= (x + 1 < sx ? x + 1 : sx - 1); i++)
              for (j = (y > 0 ? y - 1 : 0); j <= (y + 1 < sy ? y + 1 : sy - 1); j++)
                for (k = (a > 0 ? a - 1 : 0); k <= (a + 1 < sa ? a + 1 : sa - 1); k++)
                  keep_larger(i, j, k, req.new_value);
          end
          r.hit = 1'b1;
          r.entry = grid_cells[grid_index(x, y, a)];
        end
      end
      ogms_pkg::KIND_READ: begin
        if (all_ok) begin
          r.hit = 1'b1;
          r.entry = grid_cells[grid_index(x, y, a)];
        end
      end
      ogms_pkg::KIND_BEST: begin
        if (xy_ok) begin
          top = -1;
          for (k = 0; k < sa; k++) begin
            e = int'(grid_cells[grid_index(x, y, k)]);
            if (e > top) begin
              top = e;
              r.best_alpha = k[3:0];
            end
          end
          r.hit = 1'b1;
          r.entry = top[7:0];
        end
      end
      ogms_pkg::KIND_CLEAR: begin
        foreach (grid_cells[n]) grid_cells[n] = 8'd0;
        peak_value = 8'd0;
        filled_total = 32'd0;
      end
      default: ;
    endcase
    r.max_entry = peak_value;
    r.cells_filled = filled_total;
    return r;
  endfunction

  function automatic ogms_pkg::item_t make_req(logic [2:0] kind, int x, int y, int a, int v);
    ogms_pkg::item_t r;
    r.kind = kind;
    r.cell_x = x[7:0];
    r.cell_y = y[7:0];
    r.cell_alpha = a[7:0];
    r.new_value = v[7:0];
    return r;
  endfunction

  function automatic int pick_coord(int span);
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return $urandom_range(0, 255);
    if (roll == 1) return -1;
    if (roll == 2) return span;
    return $urandom_range(0, span - 1);
  endfunction

  function automatic ogms_pkg::item_t random_request();
    int roll, v;
    logic [2:0] kind;
    roll = $urandom_range(0, 99);
    if (roll < 30) kind = ogms_pkg::KIND_WRITE;
    else if (roll < 50) kind = ogms_pkg::KIND_WRITE_NB;
    else if (roll < 75) kind = ogms_pkg::KIND_READ;
    else if (roll < 95) kind = ogms_pkg::KIND_BEST;
    else kind = 3'($urandom_range(5, 7));
    roll = $urandom_range(0, 7);
    if (roll == 0) v = 0;
    else if (roll == 1) v = $urandom_range(1, 4);
    else v = $urandom_range(0, 255);
    return make_req(kind, pick_coord(eff_size(int'(size_x_reg), ogms_pkg::MAX_CELLS_X)),
                    pick_coord(eff_size(int'(size_y_reg), ogms_pkg::MAX_CELLS_Y)),
                    pick_coord(eff_size(int'(size_alpha_reg), ogms_pkg::MAX_CELLS_ALPHA)),
                    v);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch in result %0d, %s: expected %0d, got %0d",
                 results_checked, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      item_ch.data <= '0;
      src_gap = 0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        note_prediction(grid_step(item_ch.data));
        requests_sent++;
        kind_seen[item_ch.data.kind]++;
      end
      if (!item_ch.valid || item_ch.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          item_ch.valid <= 1'b0;
        end else if (queued_requests.size() > 0) begin
          item_ch.data <= queued_requests.pop_front();
          item_ch.valid <= 1'b1;
          if (sender_idles && $urandom_range(0, 3) == 0) src_gap = $urandom_range(1, 17);
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    ogms_pkg::result_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
      snk_gap = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Result transfer with no prediction pending");
        end else begin
          want = awaited_results.pop_front();
          check_field("hit", 32'(want.hit), 32'(result_ch.data.hit));
          check_field("entry", 32'(want.entry), 32'(result_ch.data.entry));
          check_field("best_alpha", 32'(want.best_alpha), 32'(result_ch.data.best_alpha));
          check_field("max_entry", 32'(want.max_entry), 32'(result_ch.data.max_entry));
          check_field("cells_filled", want.cells_filled, result_ch.data.cells_filled);
        end
        results_checked++;
      end
      if (snk_gap > 0) begin
        snk_gap--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
        if (receiver_idles && $urandom_range(0, 7) == 0) snk_gap = $urandom_range(1, 17);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [ogms_pkg::IDX_W-1:0] idx, logic [ogms_pkg::REG_W-1:0] val);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    case (idx)
      ogms_pkg::REG_SIZE_X: size_x_reg = val;
      ogms_pkg::REG_SIZE_Y: size_y_reg = val;
      ogms_pkg::REG_SIZE_ALPHA: size_alpha_reg = val[4:0];
      default: ;
    endcase
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic wait_drained();
    while (queued_requests.size() > 0 || awaited_results.size() > 0 || item_ch.valid)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(bit [6:0] sx, bit [6:0] sy, bit [4:0] sa, int count,
                           bit src_idle, bit snk_idle, bit with_clear);
    wait_drained();
    write_reg(ogms_pkg::REG_SIZE_X, sx);
    write_reg(ogms_pkg::REG_SIZE_Y, sy);
    write_reg(ogms_pkg::REG_SIZE_ALPHA, 7'(sa));
    settings_tried++;
    @(negedge clk);
    sender_idles = src_idle;
    receiver_idles = snk_idle;
    for (int n = 0; n < count; n++) begin
      if (with_clear && n == count / 2) queue_request(make_req(ogms_pkg::KIND_CLEAR, 0, 0, 0, 0));
      queue_request(random_request());
    end
  endtask

  initial begin
    item_ch.valid = 1'b0;
    item_ch.data = '0;
    result_ch.ready = 1'b0;
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    settings_tried = 1;

    queue_request(make_req(ogms_pkg::KIND_READ, 0, 0, 0, 0));
    queue_request(make_req(ogms_pkg::KIND_WRITE, 0, 0, 0, 0));
    queue_request(make_req(ogms_pkg::KIND_WRITE, 0, 0, 0, 0));
    queue_request(make_req(ogms_pkg::KIND_WRITE, 63, 63, 15, 255));
    queue_request(make_req(ogms_pkg::KIND_WRITE, 63, 63, 15, 10));
    queue_request(make_req(ogms_pkg::KIND_READ, 63, 63, 15, 0));
    queue_request(make_req(ogms_pkg::KIND_WRITE_NB, 0, 0, 0, 7));
    queue_request(make_req(ogms_pkg::KIND_WRITE_NB, 63, 63, 15, 200));
    queue_request(make_req(ogms_pkg::KIND_WRITE_NB, 10, 20, 5, 50));
    queue_request(make_req(ogms_pkg::KIND_BEST, 10, 20, 0, 0));
    queue_request(make_req(ogms_pkg::KIND_WRITE, 2, 2, 3, 9));
    queue_request(make_req(ogms_pkg::KIND_WRITE, 2, 2, 7, 9));
    queue_request(make_req(ogms_pkg::KIND_BEST, 2, 2, 0, 0));
    queue_request(make_req(ogms_pkg::KIND_BEST, 0, 0, 127, 0));
    queue_request(make_req(ogms_pkg::KIND_READ, -1, 0, 0, 0));
    queue_request(make_req(ogms_pkg::KIND_WRITE, 64, 0, 0, 1));
    queue_request(make_req(ogms_pkg::KIND_WRITE, 0, -128, 0, 1));
    queue_request(make_req(ogms_pkg::KIND_WRITE_NB, 0, 0, 127, 1));
    queue_request(make_req(ogms_pkg::KIND_READ, 0, 0, 16, 0));
    queue_request(make_req(ogms_pkg::KIND_BEST, -128, 5, 0, 0));
    queue_request(make_req(ogms_pkg::KIND_BEST, 5, 64, 0, 0));
    queue_request(make_req(3'd5, 1, 1, 1, 255));
    queue_request(make_req(3'd6, 1, 1, 1, 255));
    queue_request(make_req(3'd7, 127, -1, 127, 255));
    queue_request(make_req(ogms_pkg::KIND_CLEAR, 0, 0, 0, 0));
    queue_request(make_req(ogms_pkg::KIND_READ, 63, 63, 15, 0));
    queue_request(make_req(ogms_pkg::KIND_WRITE, 1, 2, 3, 128));

    run_phase(7'd4, 7'd4, 5'd4, 130, 1'b1, 1'b1, 1'b1);
    run_phase(7'd1, 7'd1, 5'd1, 60, 1'b0, 1'b1, 1'b0);
    run_phase(7'd127, 7'd127, 5'd31, 100, 1'b1, 1'b0, 1'b0);
    run_phase(7'd0, 7'd0, 5'd0, 40, 1'b1, 1'b1, 1'b0);
    run_phase(7'd3, 7'd7, 5'd16, 150, 1'b0, 1'b0, 1'b0);
    run_phase(7'd64, 7'd64, 5'd16, 150, 1'b1, 1'b1, 1'b1);
    run_phase(7'd2, 7'd5, 5'd3, 130, 1'b1, 1'b1, 1'b0);
    run_phase(7'($urandom_range(1, 10)), 7'($urandom_range(1, 10)),
              5'($urandom_range(1, 16)), 130, 1'b1, 1'b1, 1'b0);
    run_phase(7'd6, 7'd6, 5'd8, 130, 1'b0, 1'b0, 1'b0);
    wait_drained();

    $display("Covered %0d transfers under %0d size settings: %0d writes, %0d neighbor writes,",
             requests_sent, settings_tried, kind_seen[ogms_pkg::KIND_WRITE],
             kind_seen[ogms_pkg::KIND_WRITE_NB]);
    $display("%0d reads, %0d scans, %0d clears, %0d unknown kinds; %0d results, %0d mismatches.",
             kind_seen[ogms_pkg::KIND_READ], kind_seen[ogms_pkg::KIND_BEST],
             kind_seen[ogms_pkg::KIND_CLEAR],
             kind_seen[5] + kind_seen[6] + kind_seen[7], results_checked, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
